/* rtl/core/md5_digest_engine_unit_defines.svh */
// Assertion macros for the MD5 digest engine.
`ifndef MD5_DIGEST_ENGINE_UNIT_DEFINES_SVH
`define MD5_DIGEST_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MD5DE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("md5de assertion failed");
`define MD5DE_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("md5de assertion failed");
`else
`define MD5DE_ASSERT(lbl, prop)
`define MD5DE_ASSERT_NR(lbl, prop)
`endif
`endif

/* rtl/core/md5de_pkg.sv */
// Package: MD5 round tables and round functions.
package md5de_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  function automatic logic [31:0] md5de_k(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
        6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
        6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
        6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
        6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
        6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
        6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
        6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
        6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
        6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
        6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
        6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
        6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
        6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
        6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
        6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
        6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
        6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
        6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
        6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
        6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
        6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
        6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] md5de_s(input logic [5:0] r);
    logic [4:0] s;
    begin
      case ({r[5:4], r[1:0]})
        4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
        4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
        4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // Message word index used by a round.
  function automatic logic [3:0] md5de_g(input logic [5:0] r);
    logic [3:0] i4;
    logic [3:0] g;
    begin
      i4 = r[3:0];
      case (r[5:4])
        2'd0: g = i4;
        2'd1: g = i4 * 4'd5 + 4'd1;
        2'd2: g = i4 * 4'd3 + 4'd5;
        default: g = i4 * 4'd7;
      endcase
      return g;
    end
  endfunction

  function automatic logic [31:0] md5de_f(input logic [1:0] ph, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      case (ph)
        2'd0: f = (b & c) | (~b & d);
        2'd1: f = (d & b) | (~d & c);
        2'd2: f = b ^ c ^ d;
        default: f = c ^ (b | ~d);
      endcase
      return f;
    end
  endfunction

  function automatic logic [31:0] md5de_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    begin
      dbl = {x, x} << s;
      return dbl[63:32];
    end
  endfunction

endpackage

/* rtl/core/md5de_ram.sv */
// Generic single-port-write, registered-read RAM.
module md5de_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/core/md5_digest_engine_unit.sv */
// MD5 digest engine: byte stream in, 16 digest bytes out per message.
// A full block is compressed by the single round unit reading one message word per
// cycle from the block RAM, then added into the chaining values in a finish step.
// End of message: padding runs 1 byte per cycle outside compression, up to 64 bytes
// (72 with a second block), then 16 output words, one per cycle when the sink is ready.
// Reset (rst_ni low, async) restores initial chaining values, zero count, idle state.
`include "md5_digest_engine_unit_defines.svh"
module md5_digest_engine_unit
  import md5de_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic       s_axis_tuser,   // [0] has_byte
  input  logic       s_axis_tlast,   // end_of_message
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] digest_byte
  output logic       m_axis_tlast    // digest_last
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StComp = 3'd2;
  localparam logic [2:0] StFin  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  // padding sub-phase
  localparam logic [1:0] PsMark = 2'd0;
  localparam logic [1:0] PsZero = 2'd1;
  localparam logic [1:0] PsLen  = 2'd2;
  localparam logic [1:0] PsDone = 2'd3;

  logic [2:0]  state_q, state_d;
  logic [1:0]  psub_q, psub_d;
  logic        pad_q, pad_d;
  logic [5:0]  pos_q;          // offset in current block
  logic [60:0] cnt_q;          // message byte count, wraps mod 2^61
  logic [23:0] wacc_q;         // low bytes of the word being assembled
  logic [5:0]  rnd_q;
  logic [3:0]  ocnt_q;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic        mval_q;
  logic [7:0]  mdat_q;
  logic        mlast_q;

  logic        accept;
  logic        place_en;
  logic [7:0]  place_val;
  logic        blk_full;
  logic [63:0] len_bits;
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [31:0] rnd_t;
  logic [31:0] rnd_b;
  logic        out_load;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign len_bits      = {cnt_q, 3'b000};

  // byte source: stream in idle, padding generator in StPad, none otherwise
  always_comb begin
    place_en  = 1'b0;
    place_val = 8'h00;
    if (state_q == StIdle) begin
      place_en  = accept && s_axis_tuser;
      place_val = s_axis_tdata;
    end else if (state_q == StPad) begin
      place_en = 1'b1;
      case (psub_q)
        PsMark:  place_val = 8'h80;
        PsLen:   place_val = len_bits[{pos_q[2:0], 3'b000} +: 8];
        default: place_val = 8'h00;
      endcase
    end
  end

  assign blk_full  = place_en && (pos_q == 6'd63);
  assign ram_we    = place_en && (pos_q[1:0] == 2'd3);
  assign ram_wdata = {place_val, wacc_q};

  // prefetch: word for the next round; word 0 while a block completes.
  // Writes happen only outside compression, so no same-entry overlap.
  assign ram_raddr = (state_q == StComp) ? md5de_g(rnd_q + 6'd1) : 4'd0;

  md5de_ram #(
    .Width(32),
    .Depth(16)
  ) u_blk_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q[5:2]),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // one MD5 round
  assign rnd_t = md5de_f(rnd_q[5:4], b_q, c_q, d_q) + a_q + md5de_k(rnd_q) + ram_rdata;
  assign rnd_b = b_q + md5de_rotl(rnd_t, md5de_s(rnd_q));

  assign out_load = (state_q == StOut) && (!mval_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    psub_d  = psub_q;
    pad_d   = pad_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (s_axis_tlast) begin
            pad_d  = 1'b1;
            psub_d = PsMark;
          end
          if (blk_full) begin
            state_d = StComp;
          end else if (s_axis_tlast) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        case (psub_q) inside
          PsMark, PsZero: psub_d = (pos_q == 6'd55) ? PsLen : PsZero;
          default:        psub_d = (pos_q == 6'd63) ? PsDone : PsLen;
        endcase
        if (blk_full) begin
          state_d = StComp;
        end
      end
      StComp: begin
        if (rnd_q == 6'd63) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!pad_q) begin
          state_d = StIdle;
        end else if (psub_q == PsDone) begin
          state_d = StOut;
        end else begin
          state_d = StPad;
        end
      end
      StOut: begin
        if (out_load && (ocnt_q == 4'd15)) begin
          state_d = StIdle;
          pad_d   = 1'b0;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      psub_q  <= PsMark;
      pad_q   <= 1'b0;
      pos_q   <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      ocnt_q  <= '0;
      h_q[0]  <= InitA;
      h_q[1]  <= InitB;
      h_q[2]  <= InitC;
      h_q[3]  <= InitD;
      mval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      psub_q  <= psub_d;
      pad_q   <= pad_d;
      if (place_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (accept && s_axis_tuser) begin
        cnt_q <= cnt_q + 61'd1;
      end
      if (state_q == StComp) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (state_q == StFin) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
      end
      if (out_load) begin
        mval_q <= 1'b1;
        ocnt_q <= ocnt_q + 4'd1;
        if (ocnt_q == 4'd15) begin
          // digest captured: back to a fresh message
          h_q[0] <= InitA;
          h_q[1] <= InitB;
          h_q[2] <= InitC;
          h_q[3] <= InitD;
          cnt_q  <= '0;
          pos_q  <= '0;
        end
      end else if (m_axis_tready) begin
        mval_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (place_en) begin
      case (pos_q[1:0])
        2'd0:    wacc_q[7:0]   <= place_val;
        2'd1:    wacc_q[15:8]  <= place_val;
        2'd2:    wacc_q[23:16] <= place_val;
        default: wacc_q        <= wacc_q;
      endcase
    end
    if (blk_full) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
    end else if (state_q == StComp) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= rnd_b;
    end
    if (out_load) begin
      mdat_q  <= h_q[ocnt_q[3:2]][{ocnt_q[1:0], 3'b000} +: 8];
      mlast_q <= (ocnt_q == 4'd15);
    end
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdat_q;
  assign m_axis_tlast  = mlast_q;

  `MD5DE_ASSERT(a_no_wr_comp, (state_q == StComp) |-> !ram_we)
  `MD5DE_ASSERT(a_rnd_start, ((state_q != StComp) && (state_d == StComp)) |=> (rnd_q == 6'd0))
  `MD5DE_ASSERT(a_ready_nopad, s_axis_tready |-> !pad_q)

endmodule

/* test/tb_md5_digest_engine_unit.sv */
// MD5 digest engine testbench: directed and random messages checked by an MD5 predictor.
`timescale 1ns / 1ps
module tb_md5_digest_engine_unit;
  import md5de_pkg::*;

  // Expected digest byte with its end flag.
  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } digest_word_t;

  // Scoreboard: predicts digests from accepted input words, checks output words.
  class md5_digest_board;
    logic [31:0]  chain[4];
    logic [7:0]   blk[64];
    logic [60:0]  nbytes;
    digest_word_t pending[$];
    int           errors;

    function void clear_state();
      chain[0] = InitA; chain[1] = InitB; chain[2] = InitC; chain[3] = InitD;
      foreach (blk[i]) blk[i] = 8'h00;
      nbytes = '0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, f, t;
      int g, s;
      int rot_tab[16];
      logic [31:0] kk;
      rot_tab = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      for (int i = 0; i < 16; i++)
        w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin
          f = (b & c) | (~b & d); g = i;
        end else if (i < 32) begin
          f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
        end else if (i < 48) begin
          f = b ^ c ^ d; g = (3 * i + 5) % 16;
        end else begin
          f = c ^ (b | ~d); g = (7 * i) % 16;
        end
        kk = 32'(longint'($floor($pow(2.0, 32) * (($sin(i + 1) < 0) ? -$sin(i + 1)
                                                                        : $sin(i + 1)))));
        t = f + a + kk + w[g];
        s = rot_tab[(i / 16) * 4 + (i % 4)];
        a = d; d = c; c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endfunction

    function int place(int pos, logic [7:0] v);
      blk[pos % 64] = v;
      pos = pos % 64 + 1;
      if (pos == 64) begin
        compress();
        pos = 0;
      end
      return pos;
    endfunction

    function void note_input(logic [7:0] val, logic has_b, logic eom);
      int pos;
      logic [63:0] bits;
      digest_word_t dw;
      if (has_b) begin
        void'(place(int'(nbytes[5:0]), val));
        nbytes = nbytes + 61'd1;
      end
      if (!eom) return;
      bits = {nbytes, 3'b000};
      pos = place(int'(nbytes[5:0]), 8'h80);
      while (pos != 56) pos = place(pos, 8'h00);
      for (int i = 0; i < 8; i++) pos = place(pos, bits[8*i +: 8]);
      for (int i = 0; i < 16; i++) begin
        dw.digest_byte = chain[i / 4][8 * (i % 4) +: 8];
        dw.digest_last = (i == 15);
        pending.push_back(dw);
      end
      clear_state();
    endfunction

    task check_output(logic [7:0] got_b, logic got_l);
      digest_word_t dw;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h last %b", got_b, got_l));
        return;
      end
      dw = pending.pop_front();
      if (got_b !== dw.digest_byte)
        report_mismatch($sformatf("digest byte %h, want %h", got_b, dw.digest_byte));
      if (got_l !== dw.digest_last)
        report_mismatch($sformatf("digest last %b, want %b", got_l, dw.digest_last));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] byte_value
  logic       s_axis_tuser = 1'b0;   // [0] has_byte
  logic       s_axis_tlast = 1'b0;   // end_of_message
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] digest_byte
  logic       m_axis_tlast;          // digest_last

  md5_digest_engine_unit u_top (.*);

  md5_digest_board board = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One input word; gap drawn per word, with runs of back-to-back words.
  // Ready is sampled mid-cycle, ahead of the edge that accepts.
  bit no_gap_run = 1'b0;
  task automatic send_word(logic [7:0] val, logic has_b, logic eom);
    int gap;
    bit ok;
    gap = no_gap_run ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= has_b;
    s_axis_tlast  <= eom;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    board.note_input(val, has_b, eom);
  endtask

  // Message of n random bytes; a few idle words mixed in; end mark on last byte or alone.
  task automatic send_message(int n, bit end_alone);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      send_word(8'($urandom), 1'b1, (i == n - 1) && !end_alone);
    end
    if (end_alone || n == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // Sink: ready idles per word; checks each accepted word.
  initial begin
    int gap;
    bit seen;
    logic [7:0] got_b;
    logic got_l;
    @(posedge rst_ni);
    forever begin
      gap = no_gap_run ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        seen  = m_axis_tvalid;
        got_b = m_axis_tdata;
        got_l = m_axis_tlast;
        @(posedge clk_i);
      end while (!seen);
      board.check_output(got_b, got_l);
    end
  end

  initial begin
    board.clear_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, lone byte extremes, byte with end mark, padding edges.
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'h5a, 1'b0, 1'b1);
    // Length field no longer fits: padding spills into a second block.
    send_message(57, 1'b0);
    // Random short messages.
    for (int m = 0; m < 8; m++) begin
      no_gap_run = ($urandom_range(0, 3) == 0);
      send_message($urandom_range(0, 8), $urandom_range(0, 1));
    end
    no_gap_run = 1'b0;
    s_axis_tvalid <= 1'b0;
    wait (board.pending.size() == 0);
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_md5_digest_engine_unit: PASS");
    else
      $display("tb_md5_digest_engine_unit: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_md5_digest_engine_unit: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/md5de_pkg.sv
rtl/core/md5de_ram.sv
rtl/core/md5_digest_engine_unit.sv
test/tb_md5_digest_engine_unit.sv
